// ----- src/pe_pkg.sv -----
// package for the permutation engine: widths, operation codes, pass codes,
// controller states and the request, command and status structs
// no dependencies
package pe_pkg;

   localparam int MAX_POINTS = 64;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int LEN_W      = 7;
   localparam int OP_W       = 4;
   localparam int EXP_W      = 32;

   // operation codes
   localparam logic [OP_W-1:0] OP_WRITE      = 4'd0;
   localparam logic [OP_W-1:0] OP_WRITE_OPND = 4'd1;
   localparam logic [OP_W-1:0] OP_READ       = 4'd2;
   localparam logic [OP_W-1:0] OP_IDENTITY   = 4'd3;
   localparam logic [OP_W-1:0] OP_COMPOSE    = 4'd4;
   localparam logic [OP_W-1:0] OP_INVERSE    = 4'd5;
   localparam logic [OP_W-1:0] OP_POWER      = 4'd6;
   localparam logic [OP_W-1:0] OP_TAU_RIGHT  = 4'd7;
   localparam logic [OP_W-1:0] OP_TAU_LEFT   = 4'd8;
   localparam logic [OP_W-1:0] OP_CYCLE_FWD  = 4'd9;
   localparam logic [OP_W-1:0] OP_CYCLE_BWD  = 4'd10;

   // one sweep over table entries
   typedef enum logic [4:0] {
      P_NONE, P_IDENT, P_COMPOSE, P_POW_INIT, P_ACC, P_ACC_COPY, P_SQ, P_SQ_COPY,
      P_POW_OUT, P_INV_INIT, P_INV_SCAT, P_INV_COPY, P_TAU_SCAN, P_TAU_WR, P_SWAP,
      P_CYC_SCAN, P_CYC_APPLY, P_BCYC, P_WRITE, P_WRITE_OPND, P_READ
   } pass_type;

   typedef enum logic [1:0] {PH_IDLE, PH_RD1, PH_RD2, PH_WR} phase_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_START, ST_RD1, ST_RD2, ST_WR, ST_DONE
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]  operation;
      logic [IDX_W-1:0] first_index;
      logic [IDX_W-1:0] second_index;
      logic [LEN_W-1:0] cycle_length;
      logic [EXP_W-1:0] exponent;
   } req_type;

   typedef struct packed {
      phase_type phase;
      pass_type  pass;
      logic      accept;
      logic      flag_bad;
      logic      load_rsp;
   } cmd_type;

   typedef struct packed {
      logic            bad;
      logic            k_last;
      logic            e_zero;
      logic            e_odd;
      logic [OP_W-1:0] op;
   } stat_type;

   // first sweep of an operation
   function automatic pass_type first_pass(input logic [OP_W-1:0] op);
      pass_type p;
      case (op)
         OP_WRITE:      p = P_WRITE;
         OP_WRITE_OPND: p = P_WRITE_OPND;
         OP_READ:       p = P_READ;
         OP_IDENTITY:   p = P_IDENT;
         OP_COMPOSE:    p = P_COMPOSE;
         OP_INVERSE:    p = P_INV_INIT;
         OP_POWER:      p = P_POW_INIT;
         OP_TAU_RIGHT:  p = P_TAU_SCAN;
         OP_TAU_LEFT:   p = P_SWAP;
         OP_CYCLE_FWD:  p = P_CYC_SCAN;
         OP_CYCLE_BWD:  p = P_BCYC;
         default:       p = P_NONE;
      endcase
      return p;
   endfunction

   // sweep that follows a finished one, none when the operation is over
   function automatic pass_type next_pass(input pass_type p, input logic e_zero,
                                          input logic e_odd);
      pass_type n;
      case (p)
         P_POW_INIT, P_ACC_COPY, P_SQ_COPY:
            n = e_zero ? P_POW_OUT : (e_odd ? P_ACC : P_SQ);
         P_ACC:      n = P_ACC_COPY;
         P_SQ:       n = P_SQ_COPY;
         P_INV_INIT: n = P_INV_SCAT;
         P_INV_SCAT: n = P_INV_COPY;
         P_TAU_SCAN: n = P_TAU_WR;
         P_CYC_SCAN: n = P_CYC_APPLY;
         default:    n = P_NONE;
      endcase
      return n;
   endfunction

endpackage

// ----- src/pe_if.sv -----
// channel interfaces of the permutation engine: request, response, register write
// depends on pe_pkg
interface pe_req_if;
   logic                         valid;
   logic                         ready;
   logic [pe_pkg::OP_W-1:0]      operation;
   logic [pe_pkg::IDX_W-1:0]     first_index;
   logic [pe_pkg::IDX_W-1:0]     second_index;
   logic [pe_pkg::LEN_W-1:0]     cycle_length;
   logic [pe_pkg::EXP_W-1:0]     exponent;
   modport source (output valid, operation, first_index, second_index, cycle_length,
                   exponent, input ready);
   modport sink   (input valid, operation, first_index, second_index, cycle_length,
                   exponent, output ready);
endinterface

interface pe_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [pe_pkg::IDX_W-1:0] entry_value;
   logic                     status;
   modport source (output valid, entry_value, status, input ready);
   modport sink   (input valid, entry_value, status, output ready);
endinterface

interface pe_csr_if;
   logic                     valid;
   logic                     ready;
   logic [pe_pkg::LEN_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ----- src/pe_ctrl.sv -----
// controller of the permutation engine: sequences sweeps and phases per item
// depends on pe_pkg
module pe_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  pe_pkg::stat_type stat,
   output pe_pkg::cmd_type  cmd
);

   pe_pkg::state_type state_ff, state_in;
   pe_pkg::pass_type  pass_ff, pass_in, pass_nx;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign pass_nx  = pe_pkg::next_pass(pass_ff, stat.e_zero, stat.e_odd);

   // next state
   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      unique case (state_ff)
         pe_pkg::ST_IDLE: begin
            if (req_valid) state_in = pe_pkg::ST_START;
         end
         pe_pkg::ST_START: begin
            if (stat.bad) begin
               state_in = pe_pkg::ST_DONE;
            end else begin
               pass_in  = pe_pkg::first_pass(stat.op);
               state_in = pe_pkg::ST_RD1;
            end
         end
         pe_pkg::ST_RD1: state_in = pe_pkg::ST_RD2;
         pe_pkg::ST_RD2: state_in = pe_pkg::ST_WR;
         pe_pkg::ST_WR: begin
            if (!stat.k_last) begin
               state_in = pe_pkg::ST_RD1;
            end else if (pass_nx == pe_pkg::P_NONE) begin
               state_in = pe_pkg::ST_DONE;
            end else begin
               pass_in  = pass_nx;
               state_in = pe_pkg::ST_RD1;
            end
         end
         pe_pkg::ST_DONE: begin
            if (rsp_free) state_in = pe_pkg::ST_IDLE;
         end
         default: state_in = pe_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd          = '0;
      cmd.pass     = pass_ff;
      cmd.phase    = pe_pkg::PH_IDLE;
      req_ready    = 1'b0;
      unique case (state_ff)
         pe_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         pe_pkg::ST_START: cmd.flag_bad = stat.bad;
         pe_pkg::ST_RD1:   cmd.phase = pe_pkg::PH_RD1;
         pe_pkg::ST_RD2:   cmd.phase = pe_pkg::PH_RD2;
         pe_pkg::ST_WR:    cmd.phase = pe_pkg::PH_WR;
         pe_pkg::ST_DONE:  cmd.load_rsp = rsp_free;
         default:          cmd.phase = pe_pkg::PH_IDLE;
      endcase
   end

   // response valid, held until taken
   always_comb begin
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pe_pkg::ST_IDLE;
         pass_ff      <= pe_pkg::P_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- src/pe_datapath.sv -----
// datapath of the permutation engine: tables, sweep counter, item fields,
// range checks and response payload
// depends on pe_pkg
module pe_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  pe_pkg::cmd_type          cmd,
   output pe_pkg::stat_type         stat,
   input  pe_pkg::req_type          req,
   input  logic                     csr_write,
   input  logic [pe_pkg::LEN_W-1:0] csr_data,
   output logic [pe_pkg::IDX_W-1:0] rsp_entry_value,
   output logic                     rsp_status
);

   localparam int IW = pe_pkg::IDX_W;
   localparam int LW = pe_pkg::LEN_W;
   localparam int NP = pe_pkg::MAX_POINTS;

   // item fields
   logic [pe_pkg::OP_W-1:0]  op_ff;
   logic [IW-1:0]            a_ff, b_ff;
   logic [LW-1:0]            len_ff;
   logic [pe_pkg::EXP_W-1:0] e_ff;
   logic [LW-1:0]            plen_ff;

   // sweep state
   logic [LW-1:0] k_ff, cnt;
   logic [IW-1:0] kidx;
   logic          k_last;
   logic [IW-1:0] v1_ff, t_ff, pa_ff, pb_ff;
   logic          fa_ff, fb_ff;
   logic [NP-1:0] found_ff;
   logic [IW-1:0] value_ff, rsp_value_ff;
   logic          status_ff, rsp_status_ff;

   // tables
   logic [IW-1:0] perm_mem [NP];
   logic [IW-1:0] opnd_mem [NP];
   logic [IW-1:0] sq_mem   [NP];
   logic [IW-1:0] acc_mem  [NP];
   logic [IW-1:0] tmp_mem  [NP];
   logic [NP-1:0] pvalid_ff, ovalid_ff;
   logic [IW-1:0] perm_q, opnd_q, sq_q, acc_q, tmp_q, raddr_q;
   logic          pv_q, ov_q;
   logic [IW-1:0] perm_d, opnd_d, d;
   logic [IW-1:0] addr_bus;

   logic          perm_we, opnd_we, sq_we, acc_we, tmp_we;
   logic [IW-1:0] perm_wa, perm_wd, opnd_wa, opnd_wd, sq_wa, sq_wd;
   logic [IW-1:0] acc_wa, acc_wd, tmp_wa, tmp_wd;

   logic [LW-1:0] n_len;
   logic          pairs_ok, a_ok, span_ok, bad;
   logic          wr;
   logic [LW-1:0] cdiff;
   logic          in_rng;

   assign wr   = cmd.phase == pe_pkg::PH_WR;
   assign kidx = k_ff[IW-1:0];

   // active length, clamped
   always_comb begin
      if (plen_ff == '0) n_len = LW'(1);
      else if (plen_ff > LW'(NP)) n_len = LW'(NP);
      else n_len = plen_ff;
   end

   // range checks on the latched item
   assign a_ok     = {1'b0, a_ff} < n_len;
   assign pairs_ok = a_ok && ({1'b0, b_ff} < n_len);
   assign span_ok  = (len_ff != '0) &&
                     (({2'b0, a_ff} + {1'b0, len_ff}) <= {1'b0, n_len});

   always_comb begin
      case (op_ff)
         pe_pkg::OP_WRITE, pe_pkg::OP_WRITE_OPND,
         pe_pkg::OP_TAU_RIGHT, pe_pkg::OP_TAU_LEFT: bad = !pairs_ok;
         pe_pkg::OP_READ:                           bad = !a_ok;
         pe_pkg::OP_CYCLE_FWD, pe_pkg::OP_CYCLE_BWD: bad = !span_ok;
         pe_pkg::OP_IDENTITY, pe_pkg::OP_COMPOSE,
         pe_pkg::OP_INVERSE, pe_pkg::OP_POWER:      bad = 1'b0;
         default:                                   bad = 1'b1;
      endcase
   end

   // entries per sweep
   always_comb begin
      case (cmd.pass)
         pe_pkg::P_CYC_APPLY:  cnt = len_ff;
         pe_pkg::P_BCYC:       cnt = len_ff + LW'(1);
         pe_pkg::P_WRITE, pe_pkg::P_WRITE_OPND, pe_pkg::P_READ: cnt = LW'(1);
         pe_pkg::P_TAU_WR:     cnt = LW'(2);
         pe_pkg::P_SWAP:       cnt = LW'(3);
         default:              cnt = n_len;
      endcase
   end

   assign k_last = (k_ff + LW'(1)) == cnt;

   assign stat.bad    = bad;
   assign stat.k_last = k_last;
   assign stat.e_zero = e_ff == '0;
   assign stat.e_odd  = e_ff[0];
   assign stat.op     = op_ff;

   // entries never written read as the identity
   assign perm_d = pv_q ? perm_q : raddr_q;
   assign opnd_d = ov_q ? opnd_q : raddr_q;

   // read data select: first read in RD2, second read in WR
   always_comb begin
      if (wr) begin
         case (cmd.pass)
            pe_pkg::P_COMPOSE: d = opnd_d;
            pe_pkg::P_ACC:     d = acc_q;
            pe_pkg::P_SQ:      d = sq_q;
            default:           d = perm_d;
         endcase
      end else begin
         case (cmd.pass)
            pe_pkg::P_ACC, pe_pkg::P_SQ: d = sq_q;
            pe_pkg::P_ACC_COPY, pe_pkg::P_SQ_COPY,
            pe_pkg::P_INV_COPY, pe_pkg::P_CYC_APPLY: d = tmp_q;
            pe_pkg::P_POW_OUT: d = acc_q;
            default:           d = perm_d;
         endcase
      end
   end

   // shared read address
   always_comb begin
      addr_bus = kidx;
      if (cmd.phase == pe_pkg::PH_RD1) begin
         case (cmd.pass)
            pe_pkg::P_READ: addr_bus = a_ff;
            pe_pkg::P_SWAP: addr_bus = (k_ff == '0) ? a_ff : b_ff;
            pe_pkg::P_BCYC: addr_bus = a_ff + len_ff[IW-1:0] - IW'(1) - kidx;
            default:        addr_bus = kidx;
         endcase
      end else if (cmd.phase == pe_pkg::PH_RD2) begin
         addr_bus = d;
      end
   end

   // cycle window test on the scanned value
   assign cdiff  = {1'b0, v1_ff} - {1'b0, a_ff};
   assign in_rng = (v1_ff >= a_ff) && (cdiff < len_ff);

   // table writes
   always_comb begin
      perm_we = 1'b0; perm_wa = kidx; perm_wd = v1_ff;
      opnd_we = 1'b0; opnd_wa = a_ff; opnd_wd = b_ff;
      sq_we   = 1'b0; sq_wa   = kidx; sq_wd   = v1_ff;
      acc_we  = 1'b0; acc_wa  = kidx; acc_wd  = kidx;
      tmp_we  = 1'b0; tmp_wa  = kidx; tmp_wd  = d;
      if (wr) begin
         case (cmd.pass)
            pe_pkg::P_IDENT: begin
               perm_we = 1'b1; perm_wd = kidx;
            end
            pe_pkg::P_COMPOSE: begin
               perm_we = 1'b1; perm_wd = d;
            end
            pe_pkg::P_POW_OUT, pe_pkg::P_INV_COPY: perm_we = 1'b1;
            pe_pkg::P_WRITE: begin
               perm_we = 1'b1; perm_wa = a_ff; perm_wd = b_ff;
            end
            pe_pkg::P_WRITE_OPND: opnd_we = 1'b1;
            pe_pkg::P_TAU_WR: begin
               if (k_ff == '0) begin
                  perm_we = fa_ff; perm_wa = pa_ff; perm_wd = b_ff;
               end else begin
                  perm_we = fb_ff; perm_wa = pb_ff; perm_wd = a_ff;
               end
            end
            pe_pkg::P_SWAP: begin
               if (k_ff == LW'(1)) begin
                  perm_we = 1'b1; perm_wa = a_ff; perm_wd = v1_ff;
               end else if (k_ff == LW'(2)) begin
                  perm_we = 1'b1; perm_wa = b_ff; perm_wd = t_ff;
               end
            end
            pe_pkg::P_CYC_APPLY: begin
               perm_we = found_ff[kidx];
               perm_wa = v1_ff;
               perm_wd = ((k_ff + LW'(1)) < len_ff) ? a_ff + kidx + IW'(1) : a_ff;
            end
            pe_pkg::P_BCYC: begin
               if (k_ff == len_ff) begin
                  perm_we = 1'b1; perm_wa = a_ff; perm_wd = t_ff;
               end else if (k_ff != '0) begin
                  perm_we = 1'b1; perm_wa = a_ff + len_ff[IW-1:0] - kidx;
               end
            end
            pe_pkg::P_POW_INIT: begin
               sq_we = 1'b1; acc_we = 1'b1;
            end
            pe_pkg::P_SQ_COPY:  sq_we = 1'b1;
            pe_pkg::P_ACC_COPY: begin
               acc_we = 1'b1; acc_wd = v1_ff;
            end
            pe_pkg::P_ACC, pe_pkg::P_SQ: tmp_we = 1'b1;
            pe_pkg::P_INV_INIT: begin
               tmp_we = 1'b1; tmp_wd = kidx;
            end
            pe_pkg::P_INV_SCAT: begin
               tmp_we = {1'b0, v1_ff} < n_len; tmp_wa = v1_ff; tmp_wd = kidx;
            end
            pe_pkg::P_CYC_SCAN: begin
               tmp_we = in_rng; tmp_wa = cdiff[IW-1:0]; tmp_wd = kidx;
            end
            default: perm_we = 1'b0;
         endcase
      end
   end

   // memories, registered read on the shared address
   always_ff @(posedge clock) begin
      if (perm_we) perm_mem[perm_wa] <= perm_wd;
      if (opnd_we) opnd_mem[opnd_wa] <= opnd_wd;
      if (sq_we)   sq_mem[sq_wa]     <= sq_wd;
      if (acc_we)  acc_mem[acc_wa]   <= acc_wd;
      if (tmp_we)  tmp_mem[tmp_wa]   <= tmp_wd;
      perm_q  <= perm_mem[addr_bus];
      opnd_q  <= opnd_mem[addr_bus];
      sq_q    <= sq_mem[addr_bus];
      acc_q   <= acc_mem[addr_bus];
      tmp_q   <= tmp_mem[addr_bus];
      pv_q    <= pvalid_ff[addr_bus];
      ov_q    <= ovalid_ff[addr_bus];
      raddr_q <= addr_bus;
   end

   // written marks for the two tables that reset to the identity
   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= '0;
         ovalid_ff <= '0;
      end else begin
         if (perm_we) pvalid_ff[perm_wa] <= 1'b1;
         if (opnd_we) ovalid_ff[opnd_wa] <= 1'b1;
      end
   end

   // control registers: sweep counter, length register
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff    <= '0;
         plen_ff <= LW'(NP);
      end else begin
         if (csr_write) plen_ff <= csr_data;
         if (cmd.accept) k_ff <= '0;
         else if (wr) k_ff <= k_last ? '0 : k_ff + LW'(1);
      end
   end

   // item fields, scan results, response payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff     <= req.operation;
         a_ff      <= req.first_index;
         b_ff      <= req.second_index;
         len_ff    <= req.cycle_length;
         e_ff      <= req.exponent;
         fa_ff     <= 1'b0;
         fb_ff     <= 1'b0;
         found_ff  <= '0;
         value_ff  <= '0;
         status_ff <= 1'b0;
      end
      if (cmd.flag_bad) status_ff <= 1'b1;
      if (cmd.phase == pe_pkg::PH_RD2) v1_ff <= d;
      if (wr) begin
         case (cmd.pass)
            pe_pkg::P_READ: value_ff <= v1_ff;
            pe_pkg::P_SWAP, pe_pkg::P_BCYC: begin
               if (k_ff == '0) t_ff <= v1_ff;
            end
            pe_pkg::P_TAU_SCAN: begin
               if (v1_ff == a_ff) begin
                  pa_ff <= kidx; fa_ff <= 1'b1;
               end
               if (v1_ff == b_ff) begin
                  pb_ff <= kidx; fb_ff <= 1'b1;
               end
            end
            pe_pkg::P_CYC_SCAN: begin
               if (in_rng) found_ff[cdiff[IW-1:0]] <= 1'b1;
            end
            pe_pkg::P_ACC: begin
               if (k_last) e_ff[0] <= 1'b0;
            end
            pe_pkg::P_SQ: begin
               if (k_last) e_ff <= e_ff >> 1;
            end
            default: ;
         endcase
      end
      if (cmd.load_rsp) begin
         rsp_value_ff  <= value_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_entry_value = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

// ----- src/permutation_engine.sv -----
// permutation engine top level: one item at a time, each as sweeps over the tables
// each sweep entry steps through RD1, RD2, WR; inverse has init, scatter, copy sweeps;
// power: init, accumulate+copy per set bit, square+copy per squared bit, then output
// the next item is accepted while the previous result waits in the output register
// synchronous active-high reset: permutation and operand tables read as identity, length register 64
// depends on pe_pkg, pe_if, pe_ctrl, pe_datapath
module permutation_engine (
   input  logic    clock,
   input  logic    reset,
   pe_req_if.sink  req_ch,
   pe_rsp_if.source rsp_ch,
   pe_csr_if.sink  csr_ch
);

   pe_pkg::cmd_type  cmd;
   pe_pkg::stat_type stat;
   pe_pkg::req_type  req;

   // pack the request item
   assign req.operation    = req_ch.operation;
   assign req.first_index  = req_ch.first_index;
   assign req.second_index = req_ch.second_index;
   assign req.cycle_length = req_ch.cycle_length;
   assign req.exponent     = req_ch.exponent;

   assign csr_ch.ready = 1'b1;

   pe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pe_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req             (req),
      .csr_write       (csr_ch.valid),
      .csr_data        (csr_ch.data),
      .rsp_entry_value (rsp_ch.entry_value),
      .rsp_status      (rsp_ch.status)
   );

endmodule

// ----- src/pe_checker.sv -----
// port checks for the permutation engine, bound to the top level
// depends on pe_pkg and permutation_engine
module pe_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [pe_pkg::IDX_W-1:0] rsp_entry_value,
   input logic                     rsp_status
);

   // an accepted item keeps the block busy for at least the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request ready right after an accepted item");

   // a flagged result carries a zero value
   a_flag_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_entry_value == '0)
      else $error("flagged result with nonzero value");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_value) && $stable(rsp_status))
      else $error("stalled result changed");

endmodule

bind permutation_engine pe_checker u_pe_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_entry_value (rsp_ch.entry_value),
   .rsp_status      (rsp_ch.status)
);
